// ===== sv/cdre_pkg.sv =====
// ----------------------------------------------------------------------------
// cdre_pkg
// shared types, codes and tables of the character display refresh engine
// ----------------------------------------------------------------------------
package cdre_pkg;

    localparam int COLUMNS_DEF = 20;
    localparam int ROWS_DEF    = 4;

    localparam int ROW_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] INTERVAL_RST = 8'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH_INTERVAL = 2'd1;

    typedef enum logic [1:0] {
        ACT_TICK        = 2'd0,
        ACT_WRITE       = 2'd1,
        ACT_CLEAR_ALL   = 2'd2,
        ACT_CLEAR_RANGE = 2'd3
    } action_t;

    localparam logic [7:0] CYR_ROM [0:31] = '{
        8'h41, 8'h80, 8'h42, 8'h92, 8'h81, 8'h45, 8'h82, 8'h83,
        8'h84, 8'h85, 8'h4B, 8'h86, 8'h4D, 8'h48, 8'h4F, 8'h87,
        8'h50, 8'h43, 8'h54, 8'h88, 8'h00, 8'h58, 8'h89, 8'h8A,
        8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h01, 8'h8F, 8'hAC, 8'hAD
    };

    function automatic logic [7:0] row_address(input logic [ROW_W-1:0] row);
        logic [7:0] a;
        case (row)
            2'd0: a = 8'h80;
            2'd1: a = 8'hC0;
            2'd2: a = 8'h94;
            default: a = 8'hD4;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/cdre_ram.sv =====
// ----------------------------------------------------------------------------
// cdre_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cdre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== sv/char_display_refresh_engine_top.sv =====
// ----------------------------------------------------------------------------
// char_display_refresh_engine_top
// screen buffer and refresh sequencer for a character display controller
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) carries actions: tick, character write,
// clear all and range clear. output channel (out_valid/out_ready) carries
// bus transfers: reg_select, bus_byte and last.
// a write, a whole clear or a tick that is not due completes without leaving
// idle; a range clear steps through the positions that it clears. a due
// tick in the address phase gives one command byte; in the data phase it
// gives COLUMNS data bytes, one buffer ram read per cycle while the output
// register can load. in_ready is low while a transaction is in progress.
// the output register holds one byte; a stalled receiver holds the
// sequencer, and a new input is taken while the final byte still waits.
// reset empties the per-entry valid bits so the whole buffer reads as
// spaces, restarts the refresh at row 0 and restores the register defaults.
// configuration is written through cfg_we/cfg_index/cfg_data.
// ----------------------------------------------------------------------------
module char_display_refresh_engine_top #(
    parameter int COLUMNS = cdre_pkg::COLUMNS_DEF,
    parameter int ROWS    = cdre_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cdre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdre_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic [6:0]                    buffer_index,
    input  logic [7:0]                    char_code,
    input  logic [6:0]                    clear_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          reg_select,
    output logic [7:0]                    bus_byte,
    output logic                          last
);

    import cdre_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int IDX_W = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CMD,
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic              translate_reg;
    logic [7:0]        interval_reg;
    logic [7:0]        countdown_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              phase_reg;
    logic [CELLS-1:0]  valid_reg;
    logic [7:0]        ptr_reg;
    logic [6:0]        cnt_reg;
    logic [7:0]        cmd_byte_reg;
    logic [IDX_W-1:0]  base_reg;
    logic [COL_W-1:0]  col_reg;
    logic              rvalid_reg;
    logic              out_valid_reg;
    logic              reg_select_reg;
    logic [7:0]        bus_byte_reg;
    logic              last_reg;

    logic              accept;
    logic              can_load;
    logic              out_load;
    logic [7:0]        interval_eff;
    logic [ROW_W-1:0]  row_eff;
    logic              idx_in_range;
    logic              ram_we;
    logic              ram_re;
    logic [COL_W-1:0]  col_next;
    logic [IDX_W-1:0]  raddr;
    logic [7:0]        rdata;
    logic [7:0]        raw_byte;
    logic [7:0]        data_byte;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign can_load   = !out_valid_reg || out_ready;
    assign out_load   = can_load && ((state_reg == ST_CMD) || (state_reg == ST_EMIT));
    assign out_valid  = out_valid_reg;
    assign reg_select = reg_select_reg;
    assign bus_byte   = bus_byte_reg;
    assign last       = last_reg;

    assign interval_eff = (interval_reg == 8'd0) ? 8'd1 : interval_reg;
    assign row_eff      = ({1'b0, row_reg} >= 3'(ROWS)) ? '0 : row_reg;
    assign idx_in_range = ({1'b0, buffer_index} < 8'(CELLS));

    assign ram_we   = accept && (action_t'(action) == ACT_WRITE) && idx_in_range;
    assign col_next = (state_reg == ST_FETCH) ? '0 : col_reg + 1'b1;
    assign raddr    = base_reg + IDX_W'(col_next);
    assign ram_re   = (state_reg == ST_FETCH)
                   || ((state_reg == ST_EMIT) && can_load && (col_reg != COL_LAST));

    assign raw_byte  = rvalid_reg ? rdata : SPACE_CODE;
    assign data_byte = (translate_reg && (raw_byte[7:6] == 2'b11))
                     ? CYR_ROM[raw_byte[4:0]] : raw_byte;

    cdre_ram #(
        .WIDTH(8),
        .DEPTH(CELLS)
    ) u_buffer (
        .clk   (clk),
        .we    (ram_we),
        .waddr (buffer_index[IDX_W-1:0]),
        .wdata (char_code),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            translate_reg  <= 1'b1;
            interval_reg   <= INTERVAL_RST;
            countdown_reg  <= INTERVAL_RST;
            row_reg        <= '0;
            phase_reg      <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            ptr_reg        <= '0;
            cnt_reg        <= '0;
            cmd_byte_reg   <= '0;
            base_reg       <= '0;
            col_reg        <= '0;
            rvalid_reg     <= 1'b0;
            reg_select_reg <= 1'b0;
            bus_byte_reg   <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TRANSLATE_ENABLE: translate_reg <= cfg_data[0];
                    REG_REFRESH_INTERVAL: interval_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (ram_re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (action_t'(action))
                            ACT_WRITE:
                            begin
                                if (idx_in_range)
                                begin
                                    valid_reg[buffer_index[IDX_W-1:0]] <= 1'b1;
                                end
                            end
                            ACT_CLEAR_ALL:
                            begin
                                valid_reg     <= '0;
                                row_reg       <= '0;
                                phase_reg     <= 1'b0;
                                countdown_reg <= interval_eff;
                            end
                            ACT_CLEAR_RANGE:
                            begin
                                ptr_reg       <= {1'b0, buffer_index};
                                cnt_reg       <= clear_count;
                                row_reg       <= '0;
                                phase_reg     <= 1'b0;
                                countdown_reg <= interval_eff;
                                state_reg     <= ST_CLEAR;
                            end
                            default:
                            begin
                                if (countdown_reg > 8'd1)
                                begin
                                    countdown_reg <= countdown_reg - 8'd1;
                                end
                                else
                                begin
                                    countdown_reg <= interval_eff;
                                    if (!phase_reg)
                                    begin
                                        cmd_byte_reg <= row_address(row_eff);
                                        row_reg      <= row_eff;
                                        phase_reg    <= 1'b1;
                                        state_reg    <= ST_CMD;
                                    end
                                    else
                                    begin
                                        base_reg  <= IDX_W'(int'(row_eff) * COLUMNS);
                                        row_reg   <= ({1'b0, row_eff} == 3'(ROWS - 1))
                                                   ? '0 : row_eff + 1'b1;
                                        phase_reg <= 1'b0;
                                        state_reg <= ST_FETCH;
                                    end
                                end
                            end
                        endcase
                    end
                end

                ST_CLEAR:
                begin
                    if ((cnt_reg == 7'd0) || (ptr_reg >= 8'(CELLS)))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        valid_reg[ptr_reg[IDX_W-1:0]] <= 1'b0;
                        ptr_reg <= ptr_reg + 8'd1;
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end

                ST_CMD:
                begin
                    if (can_load)
                    begin
                        reg_select_reg <= 1'b0;
                        bus_byte_reg   <= cmd_byte_reg;
                        last_reg       <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end

                ST_FETCH:
                begin
                    col_reg   <= '0;
                    state_reg <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    if (can_load)
                    begin
                        reg_select_reg <= 1'b1;
                        bus_byte_reg   <= data_byte;
                        last_reg       <= (col_reg == COL_LAST);
                        if (col_reg == COL_LAST)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            col_reg <= col_next;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/cdre_checker.sv =====
// ----------------------------------------------------------------------------
// cdre_checker
// port level checks of the character display refresh engine
// ----------------------------------------------------------------------------
module cdre_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] action,
    input logic       out_valid,
    input logic       out_ready,
    input logic       reg_select,
    input logic [7:0] bus_byte,
    input logic       last
);

    import cdre_pkg::*;

    // a command transaction is always a single byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reg_select |-> last)
        else $error("command byte without last");

    // no new input while a row is still being sent
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reg_select && !last |-> !in_ready)
        else $error("input taken in the middle of a row");

    // writes and whole clears return to ready in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready
        && (action == ACT_WRITE || action == ACT_CLEAR_ALL) |=> in_ready)
        else $error("write or clear did not return to ready");

    // stalled output transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reg_select)
        && $stable(bus_byte) && $stable(last))
        else $error("stalled output changed");

endmodule

bind char_display_refresh_engine_top cdre_checker u_cdre_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reg_select (reg_select),
    .bus_byte   (bus_byte),
    .last       (last)
);
